// ===== rtl/rcls_pkg.sv =====
`default_nettype none

package rcls_pkg;

    // Field widths of the request and result items.
    localparam int IDX_W   = 7;
    localparam int NOISE_W = 16;
    localparam int POS_W   = 32;
    localparam int E2E_W   = 40;
    localparam int STEP_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BEAD_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SPACING = 2'd3;

    localparam logic [IDX_W-1:0] BEAD_COUNT_RST      = 7'd5;
    localparam logic [15:0]      COUPLING_RST        = 16'd6554;
    localparam logic [15:0]      NOISE_SCALE_RST     = 16'd29309;
    localparam logic [31:0]      LATTICE_SPACING_RST = 32'd16384;

    // Request kinds.
    localparam logic REQ_PLACE   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // Result queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef logic signed [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

// ===== rtl/rcls_req_if.sv =====
`default_nettype none

interface rcls_req_if
    import rcls_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [IDX_W-1:0]           bead_index;
    logic signed [NOISE_W-1:0]  noise_x;
    logic signed [NOISE_W-1:0]  noise_y;

    modport source (output valid, output req_type, output bead_index,
                    output noise_x, output noise_y, input ready);
    modport sink   (input valid, input req_type, input bead_index,
                    input noise_x, input noise_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcls_res_if.sv =====
`default_nettype none

interface rcls_res_if
    import rcls_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [E2E_W-1:0]  end_to_end_sq;
    logic [STEP_W-1:0] step_number;

    modport source (output valid, output end_to_end_sq, output step_number,
                    input ready);
    modport sink   (input valid, input end_to_end_sq, input step_number,
                     output ready);
endinterface

`default_nettype wire

// ===== rtl/rouse_chain_langevin_step_top.sv =====
`default_nettype none

// Channel   Direction  Handshake      Payload
// req       in         valid/ready    req_type, bead_index, noise_x, noise_y
// res       out        valid/ready    end_to_end_sq, step_number
// cfg       in         cfg_we         cfg_index, cfg_wdata (write only)
//
// One request is taken per cycle unless it waits as below; a result passes stages 1, 2 and 3
// and the result queue after the transfer of the last bead's request before it is offered.
// Positions live in two memories (x and y) with two read ports and one write port each.
// A request waits when it reads a bead that the request just before it writes, which
// in a two-bead chain holds back bead one of every step; it also waits while the four-entry
// result queue could overflow. Reset leaves the memories unset, so each bead is placed first.

module rouse_chain_langevin_step_top
    import rcls_pkg::*;
#(
    parameter int BEAD_DEPTH = 64
) (
    input  wire                   clk,
    input  wire                   rst_n,
    rcls_req_if.sink              req,
    rcls_res_if.source            res,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(BEAD_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] bead_count_reg;
    logic [15:0]      coupling_reg;
    logic [15:0]      noise_scale_reg;
    logic [31:0]      lattice_spacing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bead_count_reg      <= BEAD_COUNT_RST;
            coupling_reg        <= COUPLING_RST;
            noise_scale_reg     <= NOISE_SCALE_RST;
            lattice_spacing_reg <= LATTICE_SPACING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BEAD_COUNT:      bead_count_reg      <= cfg_wdata[IDX_W-1:0];
                REG_COUPLING:        coupling_reg        <= cfg_wdata[15:0];
                REG_NOISE_SCALE:     noise_scale_reg     <= cfg_wdata[15:0];
                REG_LATTICE_SPACING: lattice_spacing_reg <= cfg_wdata[31:0];
                default:             ;
            endcase
        end
    end

    // The chain length is the bead count clamped to the range from two to the
    // memory depth. Indices are seven bits wide, so it always fits seven bits.
    logic [IDX_W-1:0] chain_len;

    always_comb
    begin
        if (bead_count_reg < 7'd2)
            chain_len = 7'd2;
        else if ({25'd0, bead_count_reg} > 32'(BEAD_DEPTH))
            chain_len = IDX_W'(BEAD_DEPTH);
        else
            chain_len = bead_count_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline registers (declared early for the hazard check)
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_kind_reg;
    logic [AW-1:0]     s1_slot_reg;
    logic [AW-1:0]     s1_rslot_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic signed [NOISE_W-1:0] s1_nx_reg;
    logic signed [NOISE_W-1:0] s1_ny_reg;

    logic              s2_valid_reg;
    logic              s2_kind_reg;
    logic [AW-1:0]     s2_slot_reg;
    logic              s2_last_reg;
    pos_t              s2_self_x_reg;
    pos_t              s2_self_y_reg;
    logic signed [33:0] s2_lap_x_reg;
    logic signed [33:0] s2_lap_y_reg;
    logic signed [NOISE_W-1:0] s2_nx_reg;
    logic signed [NOISE_W-1:0] s2_ny_reg;
    logic signed [32:0] s2_dx_reg;
    logic signed [32:0] s2_dy_reg;
    pos_t              s2_place_reg;

    logic              s3_valid_reg;
    logic [57:0]       s3_sqx_reg;
    logic [57:0]       s3_sqy_reg;

    logic              wb_valid_reg;
    logic [AW-1:0]     wb_slot_reg;
    pos_t              wb_x_reg;
    pos_t              wb_y_reg;

    logic [OQ_CW-1:0]  oq_cnt_reg;

    // ------------------------------------------------------------------
    // Request stage: decode, hazard check, memory read
    // ------------------------------------------------------------------
    logic          in_idx_ok;
    logic          in_first;
    logic          in_last;
    logic [AW-1:0] in_slot;
    logic [AW-1:0] in_rslot;
    logic          hazard;
    logic [OQ_CW-1:0] results_pending;
    logic          credit_ok;
    logic          req_fire;

    assign in_idx_ok = (req.bead_index != 7'd0) && (req.bead_index <= chain_len);
    assign in_first  = (req.bead_index == 7'd1);
    assign in_last   = (req.bead_index == chain_len);
    assign in_slot   = AW'(req.bead_index - 7'd1);
    // The last bead is its own right neighbour, so it reads its own entry twice.
    assign in_rslot  = in_last ? in_slot : in_slot + AW'(1);

    // The request in the first stage writes its bead too late for a request that
    // reads the same entry now, so such a request waits.
    assign hazard = s1_valid_reg && in_idx_ok &&
                    ((s1_slot_reg == in_slot) || (!in_last && (s1_slot_reg == in_rslot)));

    // Every result that may still arrive must find room in the queue.
    assign results_pending = oq_cnt_reg
                           + OQ_CW'(s1_valid_reg && s1_kind_reg && s1_last_reg)
                           + OQ_CW'(s2_valid_reg && s2_kind_reg && s2_last_reg)
                           + OQ_CW'(s3_valid_reg);
    assign credit_ok = results_pending < OQ_CW'(OQ_DEPTH);

    assign req.ready = credit_ok && !hazard;
    assign req_fire  = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Position memories
    // ------------------------------------------------------------------
    pos_t pos_x_mem [BEAD_DEPTH];
    pos_t pos_y_mem [BEAD_DEPTH];
    pos_t rd_self_x_reg;
    pos_t rd_self_y_reg;
    pos_t rd_right_x_reg;
    pos_t rd_right_y_reg;
    pos_t wr_x;
    pos_t wr_y;

    always_ff @(posedge clk)
    begin
        rd_self_x_reg  <= pos_x_mem[in_slot];
        rd_right_x_reg <= pos_x_mem[in_rslot];
        if (s2_valid_reg)
        begin
            pos_x_mem[s2_slot_reg] <= wr_x;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_self_y_reg  <= pos_y_mem[in_slot];
        rd_right_y_reg <= pos_y_mem[in_rslot];
        if (s2_valid_reg)
        begin
            pos_y_mem[s2_slot_reg] <= wr_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: forwarding, Laplacian, end-to-end difference, place value
    // ------------------------------------------------------------------
    pos_t left_old_x_reg;
    pos_t left_old_y_reg;
    pos_t head_old_x_reg;
    pos_t head_old_y_reg;

    pos_t self_x;
    pos_t self_y;
    pos_t right_x;
    pos_t right_y;
    pos_t left_x;
    pos_t left_y;
    logic signed [33:0] lap_x;
    logic signed [33:0] lap_y;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [POS_W+AW-1:0] place_prod;
    pos_t place_val;

    // The entry written in the same cycle as the memory read is missed by the
    // read, so it is taken from the write-back copy instead.
    always_comb
    begin
        self_x  = rd_self_x_reg;
        self_y  = rd_self_y_reg;
        right_x = rd_right_x_reg;
        right_y = rd_right_y_reg;
        if (wb_valid_reg && (wb_slot_reg == s1_slot_reg))
        begin
            self_x = wb_x_reg;
            self_y = wb_y_reg;
        end
        if (wb_valid_reg && (wb_slot_reg == s1_rslot_reg))
        begin
            right_x = wb_x_reg;
            right_y = wb_y_reg;
        end
        // For the last bead the right neighbour is the bead itself.
        if (s1_last_reg)
        begin
            right_x = self_x;
            right_y = self_y;
        end
    end

    assign left_x = s1_first_reg ? self_x : left_old_x_reg;
    assign left_y = s1_first_reg ? self_y : left_old_y_reg;

    assign lap_x = 34'(left_x) + 34'(right_x) - (34'(self_x) <<< 1);
    assign lap_y = 34'(left_y) + 34'(right_y) - (34'(self_y) <<< 1);

    assign dx = 33'(self_x) - 33'(head_old_x_reg);
    assign dy = 33'(self_y) - 33'(head_old_y_reg);

    assign place_prod = (POS_W+AW)'(lattice_spacing_reg) * (POS_W+AW)'(s1_slot_reg);
    assign place_val  = (place_prod > (POS_W+AW)'(POS_MAX)) ? POS_MAX
                                                             : pos_t'(place_prod[POS_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_old_x_reg <= '0;
            left_old_y_reg <= '0;
            head_old_x_reg <= '0;
            head_old_y_reg <= '0;
        end
        else if (s1_valid_reg && (s1_kind_reg == REQ_ADVANCE))
        begin
            left_old_x_reg <= self_x;
            left_old_y_reg <= self_y;
            if (s1_first_reg)
            begin
                head_old_x_reg <= self_x;
                head_old_y_reg <= self_y;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: drift and kick products, new position, squares
    // ------------------------------------------------------------------
    logic signed [50:0] drift_prod_x;
    logic signed [50:0] drift_prod_y;
    logic signed [32:0] kick_prod_x;
    logic signed [32:0] kick_prod_y;
    logic signed [36:0] sum_x;
    logic signed [36:0] sum_y;
    pos_t new_x;
    pos_t new_y;
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic [55:0] mag_sq_x;
    logic [55:0] mag_sq_y;
    logic [57:0] sq_x;
    logic [57:0] sq_y;

    assign drift_prod_x = s2_lap_x_reg * $signed({1'b0, coupling_reg});
    assign drift_prod_y = s2_lap_y_reg * $signed({1'b0, coupling_reg});
    assign kick_prod_x  = s2_nx_reg * $signed({1'b0, noise_scale_reg});
    assign kick_prod_y  = s2_ny_reg * $signed({1'b0, noise_scale_reg});

    // Dropping the low bits of a two's complement product rounds towards minus
    // infinity, which is the floor the arithmetic calls for.
    assign sum_x = {{5{s2_self_x_reg[31]}}, s2_self_x_reg}
                 + {{2{drift_prod_x[50]}}, drift_prod_x[50:16]}
                 + {{16{kick_prod_x[32]}}, kick_prod_x[32:12]};
    assign sum_y = {{5{s2_self_y_reg[31]}}, s2_self_y_reg}
                 + {{2{drift_prod_y[50]}}, drift_prod_y[50:16]}
                 + {{16{kick_prod_y[32]}}, kick_prod_y[32:12]};

    assign new_x = (sum_x > 37'(POS_MAX)) ? POS_MAX :
                   (sum_x < 37'(POS_MIN)) ? POS_MIN : pos_t'(sum_x[31:0]);
    assign new_y = (sum_y > 37'(POS_MAX)) ? POS_MAX :
                   (sum_y < 37'(POS_MIN)) ? POS_MIN : pos_t'(sum_y[31:0]);

    assign wr_x = (s2_kind_reg == REQ_ADVANCE) ? new_x : s2_place_reg;
    assign wr_y = (s2_kind_reg == REQ_ADVANCE) ? new_y : '0;

    assign mag_x = s2_dx_reg[32] ? 33'(-s2_dx_reg) : 33'(s2_dx_reg);
    assign mag_y = s2_dy_reg[32] ? 33'(-s2_dy_reg) : 33'(s2_dy_reg);

    assign mag_sq_x = mag_x[27:0] * mag_x[27:0];
    assign mag_sq_y = mag_y[27:0] * mag_y[27:0];

    // A difference of 2^28 or more already saturates the result, so such a
    // square is replaced by a fixed large value and the multiplier stays narrow.
    assign sq_x = (mag_x[32:28] != 5'd0) ? 58'(1) << 57 : {2'b00, mag_sq_x};
    assign sq_y = (mag_y[32:28] != 5'd0) ? 58'(1) << 57 : {2'b00, mag_sq_y};

    // ------------------------------------------------------------------
    // Stage 3: end-to-end distance
    // ------------------------------------------------------------------
    logic [58:0]      sq_sum;
    logic [42:0]      sq_shift;
    logic [E2E_W-1:0] e2e;

    assign sq_sum   = 59'(s3_sqx_reg) + 59'(s3_sqy_reg);
    assign sq_shift = sq_sum[58:16];
    assign e2e      = (sq_shift[42:40] != 3'd0) ? {E2E_W{1'b1}} : sq_shift[E2E_W-1:0];

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req_fire && in_idx_ok;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && (s2_kind_reg == REQ_ADVANCE) && s2_last_reg;
            wb_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg   <= req.req_type;
        s1_slot_reg   <= in_slot;
        s1_rslot_reg  <= in_rslot;
        s1_first_reg  <= in_first;
        s1_last_reg   <= in_last;
        s1_nx_reg     <= req.noise_x;
        s1_ny_reg     <= req.noise_y;

        s2_kind_reg   <= s1_kind_reg;
        s2_slot_reg   <= s1_slot_reg;
        s2_last_reg   <= s1_last_reg;
        s2_self_x_reg <= self_x;
        s2_self_y_reg <= self_y;
        s2_lap_x_reg  <= lap_x;
        s2_lap_y_reg  <= lap_y;
        s2_nx_reg     <= s1_nx_reg;
        s2_ny_reg     <= s1_ny_reg;
        s2_dx_reg     <= dx;
        s2_dy_reg     <= dy;
        s2_place_reg  <= place_val;

        s3_sqx_reg    <= sq_x;
        s3_sqy_reg    <= sq_y;

        wb_slot_reg   <= s2_slot_reg;
        wb_x_reg      <= wr_x;
        wb_y_reg      <= wr_y;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    logic [E2E_W-1:0]  oq_e2e_reg  [OQ_DEPTH];
    logic [STEP_W-1:0] oq_step_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]  oq_wr_ptr_reg;
    logic [OQ_AW-1:0]  oq_rd_ptr_reg;
    logic [STEP_W-1:0] steps_done_reg;
    logic [STEP_W-1:0] steps_done_next;
    logic              oq_push;
    logic              oq_pop;

    assign oq_push         = s3_valid_reg;
    assign oq_pop          = res.valid && res.ready;
    assign steps_done_next = steps_done_reg + STEP_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg  <= '0;
            oq_rd_ptr_reg  <= '0;
            oq_cnt_reg     <= '0;
            steps_done_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_ptr_reg  <= oq_wr_ptr_reg + OQ_AW'(1);
                steps_done_reg <= steps_done_next;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + OQ_AW'(1);
            end
            oq_cnt_reg <= oq_cnt_reg + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_e2e_reg[oq_wr_ptr_reg]  <= e2e;
            oq_step_reg[oq_wr_ptr_reg] <= steps_done_next;
        end
    end

    assign res.valid         = (oq_cnt_reg != '0);
    assign res.end_to_end_sq = oq_e2e_reg[oq_rd_ptr_reg];
    assign res.step_number   = oq_step_reg[oq_rd_ptr_reg];

endmodule

`default_nettype wire

// ===== verif/rouse_chain_langevin_step_top_tb.sv =====
`default_nettype none

module rouse_chain_langevin_step_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcls_pkg::*;

    localparam int BEAD_DEPTH = 64;

    // Cycles allowed after the last expected result before the configuration is
    // touched or the run is closed. A placement or an ignored request produces no
    // result, so this is a safe margin.
    localparam int DRAIN_CYCLES = 12;

    // Target number of chain-changing requests over all phases together.
    localparam int RANDOM_ITEMS = 1270;

    localparam longint E2E_CAP = (longint'(1) << E2E_W) - 1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rcls_req_if req_ch ();
    rcls_res_if res_ch ();

    rouse_chain_langevin_step_top #(
        .BEAD_DEPTH(BEAD_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .res(res_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    typedef struct {
        logic [E2E_W-1:0]  e2e;
        logic [STEP_W-1:0] step;
    } chain_result_t;

    // The scoreboard keeps its own copy of the bead positions and registers,
    // applies every accepted request, and queues a result for each last-bead advance.
    class chain_scoreboard;
        int     bead_count;
        longint coupling;
        longint noise_scale;
        longint spacing;

        logic signed [POS_W-1:0] pos_x [BEAD_DEPTH];
        logic signed [POS_W-1:0] pos_y [BEAD_DEPTH];
        logic signed [POS_W-1:0] left_x, left_y;
        logic signed [POS_W-1:0] head_x, head_y;
        logic [STEP_W-1:0]       steps;

        chain_result_t expected_q[$];
        int            errors;

        function new();
            bead_count  = int'(BEAD_COUNT_RST);
            coupling    = longint'(COUPLING_RST);
            noise_scale = longint'(NOISE_SCALE_RST);
            spacing     = longint'(LATTICE_SPACING_RST);
            left_x = '0;
            left_y = '0;
            head_x = '0;
            head_y = '0;
            steps  = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_BEAD_COUNT:      bead_count  = int'(value[IDX_W-1:0]);
                REG_COUPLING:        coupling    = longint'(value[15:0]);
                REG_NOISE_SCALE:     noise_scale = longint'(value[15:0]);
                REG_LATTICE_SPACING: spacing     = longint'(value);
                default: ;
            endcase
        endfunction

        function int chain_len();
            if (bead_count < 2)
                return 2;
            if (bead_count > BEAD_DEPTH)
                return BEAD_DEPTH;
            return bead_count;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One Euler-Maruyama move of one coordinate: spring drift plus noise kick.
        function logic signed [POS_W-1:0] moved_coord(logic signed [POS_W-1:0] cur,
                                                       logic signed [POS_W-1:0] lft,
                                                       logic signed [POS_W-1:0] rgt,
                                                       logic signed [NOISE_W-1:0] noise);
            longint lap, drift, kick, sum;
            lap   = longint'(lft) + longint'(rgt) - 2 * longint'(cur);
            drift = (lap * coupling) >>> 16;
            kick  = (longint'(noise) * noise_scale) >>> 12;
            sum   = longint'(cur) + drift + kick;
            if (sum > longint'(POS_MAX))
                return POS_MAX;
            if (sum < longint'(POS_MIN))
                return POS_MIN;
            return POS_W'(sum);
        endfunction

        function longint sq_diff(logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0)
                d = -d;
            if (d >= (longint'(1) << 28))
                return longint'(1) << 57;
            return d * d;
        endfunction

        function void note_request(logic kind, logic [IDX_W-1:0] idx,
                                   logic signed [NOISE_W-1:0] nx,
                                   logic signed [NOISE_W-1:0] ny);
            int n, slot;
            longint placed, total, e2e;
            logic signed [POS_W-1:0] cx, cy, lx, ly, rx, ry;
            chain_result_t outcome;
            n = chain_len();
            if (idx == '0 || int'(idx) > n)
                return;
            slot = int'(idx) - 1;
            if (kind == REQ_PLACE) begin
                placed = spacing * slot;
                pos_x[slot] = (placed > longint'(POS_MAX)) ? POS_MAX : POS_W'(placed);
                pos_y[slot] = '0;
                return;
            end
            cx = pos_x[slot];
            cy = pos_y[slot];
            if (slot == 0) begin
                lx = cx;
                ly = cy;
                head_x = cx;
                head_y = cy;
            end
            else begin
                lx = left_x;
                ly = left_y;
            end
            if (int'(idx) < n) begin
                rx = pos_x[slot + 1];
                ry = pos_y[slot + 1];
            end
            else begin
                rx = cx;
                ry = cy;
            end
            pos_x[slot] = moved_coord(cx, lx, rx, nx);
            pos_y[slot] = moved_coord(cy, ly, ry, ny);
            left_x = cx;
            left_y = cy;
            if (int'(idx) == n) begin
                total = sq_diff(cx, head_x) + sq_diff(cy, head_y);
                e2e = total >>> 16;
                if (e2e > E2E_CAP)
                    e2e = E2E_CAP;
                steps = steps + 1'b1;
                outcome.e2e  = E2E_W'(e2e);
                outcome.step = steps;
                expected_q.push_back(outcome);
            end
        endfunction

        function void check_result(logic [E2E_W-1:0] e2e, logic [STEP_W-1:0] step);
            chain_result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: end_to_end_sq %0d step_number %0d", e2e, step);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (e2e !== want.e2e) begin
                $error("end_to_end_sq: expected %0d, actual %0d", want.e2e, e2e);
                errors++;
            end
            if (step !== want.step) begin
                $error("step_number: expected %0d, actual %0d", want.step, step);
                errors++;
            end
        endfunction
    endclass

    chain_scoreboard sb;

    // Idling controls for the driving and receiving processes, and the count of
    // chain-changing requests. Each side draws a fresh wait, from none up to its
    // maximum, before every transfer; a maximum of zero gives a stretch of back-to-back traffic.
    int tx_gap_max;
    int rx_gap_max;
    int rx_hold_cycles;
    int chain_items;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous fixed limit: far beyond the slowest correct run, even with every
    // transfer taking its longest gap on both sides and the long receiver hold.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Noise samples: mostly uniform over the whole 16-bit range, so that every
    // bit toggles, with the two extremes and zero mixed in.
    function automatic logic signed [NOISE_W-1:0] rand_noise();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 16'sh8000;
        if (pick == 1)
            return 16'sh7FFF;
        if (pick == 2)
            return '0;
        return NOISE_W'($urandom);
    endfunction

    // Register values for the Q0.16 coefficients, with the extremes favoured.
    function automatic logic [CFG_DATA_W-1:0] rand_coeff();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return 32'h0000_FFFF;
        return CFG_DATA_W'($urandom_range(0, 65535));
    endfunction

    // One request transfer. Valid drops only for a drawn gap; otherwise it stays
    // high into the next request so that back-to-back transfers happen.
    task automatic send_req(input logic kind, input logic [IDX_W-1:0] idx,
                            input logic signed [NOISE_W-1:0] nx,
                            input logic signed [NOISE_W-1:0] ny);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.bead_index <= idx;
        req_ch.noise_x    <= nx;
        req_ch.noise_y    <= ny;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(kind, idx, nx, ny);
    endtask

    // Lets the chain drain: every expected result must have been taken, then a
    // wait of DRAIN_CYCLES covers a placement still in flight behind the last result.
    task automatic settle_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges; the block is idle here.
    task automatic write_regs(input logic [CFG_DATA_W-1:0] bcount,
                              input logic [CFG_DATA_W-1:0] coup,
                              input logic [CFG_DATA_W-1:0] nscale,
                              input logic [CFG_DATA_W-1:0] spacing);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BEAD_COUNT;
        cfg_wdata <= bcount;
        @(posedge clk);
        cfg_index <= REG_COUPLING;
        cfg_wdata <= coup;
        @(posedge clk);
        cfg_index <= REG_NOISE_SCALE;
        cfg_wdata <= nscale;
        @(posedge clk);
        cfg_index <= REG_LATTICE_SPACING;
        cfg_wdata <= spacing;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(REG_BEAD_COUNT, bcount);
        sb.write_reg(REG_COUPLING, coup);
        sb.write_reg(REG_NOISE_SCALE, nscale);
        sb.write_reg(REG_LATTICE_SPACING, spacing);
    endtask

    // A request outside the regular sweep: an index the block must ignore, a bead
    // put back on the lattice mid-step, or an advance out of order. All beads in
    // use have been placed by now, so none of these reads an unwritten entry.
    task automatic send_stray(input int n);
        int pick;
        logic [IDX_W-1:0] bad;
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            bad = ($urandom_range(0, 3) == 0) ? '0 : IDX_W'($urandom_range(n + 1, 127));
            send_req(($urandom_range(0, 1) == 0) ? REQ_PLACE : REQ_ADVANCE, bad,
                     rand_noise(), rand_noise());
        end
        else if (pick == 1) begin
            send_req(REQ_PLACE, IDX_W'($urandom_range(1, n)), rand_noise(), rand_noise());
            chain_items++;
        end
        else begin
            send_req(REQ_ADVANCE, IDX_W'($urandom_range(1, n)), rand_noise(), rand_noise());
            chain_items++;
        end
    endtask

    // One phase: new register settings, the whole chain placed on the lattice,
    // then a number of full time steps with beads in order, sprinkled with
    // stray requests.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] bcount,
                             input logic [CFG_DATA_W-1:0] coup,
                             input logic [CFG_DATA_W-1:0] nscale,
                             input logic [CFG_DATA_W-1:0] spacing,
                             input int steps, input int tx_max, input int rx_max,
                             input int hold);
        int n;
        settle_idle();
        write_regs(bcount, coup, nscale, spacing);
        n = sb.chain_len();
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        rx_hold_cycles = hold;
        for (int b = 1; b <= n; b++) begin
            send_req(REQ_PLACE, IDX_W'(b), rand_noise(), rand_noise());
            chain_items++;
        end
        for (int s = 0; s < steps; s++) begin
            for (int b = 1; b <= n; b++) begin
                if ($urandom_range(0, 11) == 0)
                    send_stray(n);
                send_req(REQ_ADVANCE, IDX_W'(b), rand_noise(), rand_noise());
                chain_items++;
            end
        end
    endtask

    // Directed opening on the reset settings (five beads): lattice placement,
    // ignored indexes, the noise extremes, an out-of-order advance that touches
    // the bead just written, and a re-placement followed at once by an advance.
    task automatic run_directed();
        tx_gap_max = 0;
        rx_gap_max = 0;
        for (int b = 1; b <= 5; b++)
            send_req(REQ_PLACE, IDX_W'(b), '0, '0);
        send_req(REQ_ADVANCE, 7'd0, 16'sh7FFF, 16'sh7FFF);
        send_req(REQ_PLACE, 7'd6, '0, '0);
        send_req(REQ_ADVANCE, 7'd127, 16'sh8000, 16'sh8000);
        send_req(REQ_ADVANCE, 7'd1, 16'sh8000, 16'sh7FFF);
        send_req(REQ_ADVANCE, 7'd2, 16'sh7FFF, 16'sh8000);
        send_req(REQ_ADVANCE, 7'd3, 16'sh0000, 16'sh0000);
        send_req(REQ_ADVANCE, 7'd4, 16'shFFFF, 16'sh0001);
        send_req(REQ_ADVANCE, 7'd5, 16'sh5555, 16'shAAAA);
        send_req(REQ_ADVANCE, 7'd3, 16'sh1000, 16'shF000);
        send_req(REQ_ADVANCE, 7'd3, 16'sh2000, 16'shE000);
        send_req(REQ_ADVANCE, 7'd5, 16'sh0FFF, 16'sh7000);
        send_req(REQ_ADVANCE, 7'd1, 16'sh8001, 16'sh0800);
        send_req(REQ_PLACE, 7'd2, '0, '0);
        send_req(REQ_ADVANCE, 7'd2, 16'sh3333, 16'shCCCC);
        send_req(REQ_ADVANCE, 7'd4, 16'sh0000, 16'sh7FFF);
        send_req(REQ_ADVANCE, 7'd5, 16'sh8000, 16'sh0000);
    endtask

    // Receiving side. A long hold, when requested, replaces one drawn gap; the
    // count runs here, independent of the driver, which keeps offering requests
    // until the result queue fills and the block stalls its input.
    initial begin
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            int gap;
            gap = (rx_hold_cycles > 0) ? rx_hold_cycles : $urandom_range(0, rx_gap_max);
            rx_hold_cycles = 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            sb.check_result(res_ch.end_to_end_sq, res_ch.step_number);
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] bcount, spacing;
        int n, steps, mode;
        sb = new();
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_cycles = 0;
        chain_items = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PLACE;
        req_ch.bead_index = '0;
        req_ch.noise_x = '0;
        req_ch.noise_y = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Register extremes. A bead count of 0 or 1 runs as two beads, and one
        // of 127 as the full chain. The all-ones spacing puts every bead but the
        // first at the positive limit, which saturates the squared distance.
        run_phase(32'd2, 32'd0, 32'd0, 32'd0, 6, 8, 8, 0);
        run_phase(32'd64, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 2, 0, 0, 0);
        run_phase(32'd0, 32'h0000_FFFF, 32'd0, 32'h7FFF_FFFF, 8, 8, 0, 0);
        run_phase(32'd127, 32'd0, 32'h0000_FFFF, 32'h0100_0000, 2, 0, 8, 0);
        run_phase(32'd1, 32'd32768, 32'd1, 32'd1, 8, 0, 0, 0);
        run_phase(32'd3, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 12, 3, 3, 0);

        // Back pressure: a short chain gives a result every second request, so a
        // long receiver hold fills the result queue while the driver pushes on.
        run_phase(32'd2, 32'd40000, 32'd20000, 32'h0002_0000, 40, 0, 0, 300);

        // Random phases until enough chain-changing requests have gone through.
        // Most chains are short, so time steps complete often; a few are long.
        while (chain_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                bcount = CFG_DATA_W'($urandom_range(0, 127));
            else
                bcount = CFG_DATA_W'($urandom_range(2, 10));
            if ($urandom_range(0, 5) == 0)
                spacing = CFG_DATA_W'($urandom);
            else
                spacing = CFG_DATA_W'($urandom_range(0, 32'h0004_0000));
            n = (bcount < 2) ? 2 : ((bcount > BEAD_DEPTH) ? BEAD_DEPTH : int'(bcount));
            steps = (n >= 24) ? 2 : $urandom_range(4, 16);
            mode = $urandom_range(0, 3);
            run_phase(bcount, rand_coeff(), rand_coeff(), spacing, steps,
                      (mode[0] == 1'b1) ? 8 : 0, (mode[1] == 1'b1) ? 8 : 0, 0);
        end

        settle_idle();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
